/* rtl/core/assert_macros.svh */
// assertion macros shared by the frame boundary finder modules
// needs clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mvfb_pkg.sv */
// shared types, constants and the code classifier of the frame boundary finder
// no dependencies
package mvfb_pkg;

	localparam int QDEPTH = 4;

	// level encodings, sync sits above every level
	localparam logic [2:0] LVL_NONE     = 3'd0;
	localparam logic [2:0] LVL_SEQUENCE = 3'd1;
	localparam logic [2:0] LVL_GOP      = 3'd2;
	localparam logic [2:0] LVL_PICTURE  = 3'd3;
	localparam logic [2:0] LVL_SLICE    = 3'd4;
	localparam logic [2:0] LVL_SYNC     = 3'd7;

	localparam logic [1:0] BND_NONE   = 2'd0;
	localparam logic [1:0] BND_PREFIX = 2'd1;
	localparam logic [1:0] BND_AFTER  = 2'd2;

	localparam logic [7:0] CODE_PICTURE = 8'h00;
	localparam logic [7:0] CODE_SEQ_HDR = 8'hB3;
	localparam logic [7:0] CODE_SEQ_END = 8'hB7;
	localparam logic [7:0] CODE_GOP     = 8'hB8;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;
	localparam logic [7:0] BYTE_ONE     = 8'h01;

	localparam logic [1:0] ZRUN_MAX = 2'd2;

	// one classified byte on its way from front to back
	typedef struct packed {
		logic       code_valid;
		logic [7:0] code;
		logic [2:0] lvl;
		logic       seq_end;
		logic       resync;
	} q_item_t;

	function automatic logic [2:0] classify(input logic [7:0] code);
		logic [2:0] lvl;
		lvl = LVL_NONE;
		if (code == CODE_PICTURE) begin
			lvl = LVL_PICTURE;
		end else if (code inside {[8'h01:8'hAF]}) begin
			lvl = LVL_SLICE;
		end else if (code == CODE_SEQ_HDR) begin
			lvl = LVL_SEQUENCE;
		end else if (code == CODE_GOP) begin
			lvl = LVL_GOP;
		end
		return lvl;
	endfunction

endpackage

/* rtl/core/mvfb_in_if.sv */
// input channel of the frame boundary finder: one stream byte per item
// no dependencies
interface mvfb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       resync;

	modport source(output valid, data_byte, resync, input ready);
	modport sink(input valid, data_byte, resync, output ready);
endinterface

/* rtl/core/mvfb_out_if.sv */
// result channel of the frame boundary finder: one result item per byte
// no dependencies
interface mvfb_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] boundary;
	logic       code_valid;
	logic [7:0] code_byte;

	modport source(output valid, boundary, code_valid, code_byte, input ready);
	modport sink(input valid, boundary, code_valid, code_byte, output ready);
endinterface

/* rtl/core/mvfb_front.sv */
// front part: start code prefix scanner and code byte classifier
// depends on mvfb_pkg, mvfb_in_if
module mvfb_front (
	input  logic              clk,
	input  logic              arst_n,
	mvfb_in_if.sink           in_ch,
	output logic              push_valid,
	input  logic              push_ready,
	output mvfb_pkg::q_item_t push_item
);

	logic [1:0] zero_run_q;
	logic       code_pending_q;
	logic       accept;

	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid;
	assign accept      = in_ch.valid && push_ready;

	always_comb begin
		push_item            = '0;
		push_item.resync     = in_ch.resync;
		push_item.code_valid = code_pending_q;
		push_item.seq_end    = code_pending_q && (in_ch.data_byte == mvfb_pkg::CODE_SEQ_END);
		push_item.lvl        = mvfb_pkg::classify(in_ch.data_byte);
		if (code_pending_q) begin
			push_item.code = in_ch.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q     <= 2'd0;
			code_pending_q <= 1'b0;
		end else if (accept) begin
			if (code_pending_q) begin
				// the code byte never counts toward a new prefix
				code_pending_q <= 1'b0;
				zero_run_q     <= 2'd0;
			end else if (in_ch.data_byte == mvfb_pkg::BYTE_ZERO) begin
				if (zero_run_q != mvfb_pkg::ZRUN_MAX) begin
					zero_run_q <= zero_run_q + 2'd1;
				end
			end else if (in_ch.data_byte == mvfb_pkg::BYTE_ONE &&
			             zero_run_q == mvfb_pkg::ZRUN_MAX) begin
				code_pending_q <= 1'b1;
				zero_run_q     <= 2'd0;
			end else begin
				zero_run_q <= 2'd0;
			end
		end
	end

endmodule

/* rtl/core/mvfb_fifo.sv */
// short queue of classified items between front and back
// depends on mvfb_pkg, assert_macros.svh
`include "assert_macros.svh"

module mvfb_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  mvfb_pkg::q_item_t push_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output mvfb_pkg::q_item_t pop_item
);

	localparam int PtrW = $clog2(mvfb_pkg::QDEPTH);
	localparam int CntW = $clog2(mvfb_pkg::QDEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(mvfb_pkg::QDEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(mvfb_pkg::QDEPTH);

	mvfb_pkg::q_item_t mem_q [mvfb_pkg::QDEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CntFull);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= CntFull, "queue fill count above depth")
	`ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CntW'(1), "push lost")

endmodule

/* rtl/core/mvfb_back.sv */
// back part: level state tracking, boundary decision and result register
// depends on mvfb_pkg, mvfb_out_if, assert_macros.svh
`include "assert_macros.svh"

module mvfb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  mvfb_pkg::q_item_t pop_item,
	mvfb_out_if.source        out_ch
);

	logic [2:0] level_q;
	logic       out_valid_q;
	logic [1:0] boundary_q;
	logic       code_valid_q;
	logic [7:0] code_byte_q;

	logic [2:0] lvl_cur;
	logic [2:0] lvl_next;
	logic [1:0] bnd;
	logic       pop;

	assign pop_ready = !out_valid_q || out_ch.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		lvl_cur  = pop_item.resync ? mvfb_pkg::LVL_SYNC : level_q;
		lvl_next = lvl_cur;
		bnd      = mvfb_pkg::BND_NONE;
		if (pop_item.code_valid) begin
			if (pop_item.seq_end) begin
				bnd      = mvfb_pkg::BND_AFTER;
				lvl_next = mvfb_pkg::LVL_SEQUENCE;
			end else if (pop_item.lvl != mvfb_pkg::LVL_NONE) begin
				// back up to picture or above, or first picture or slice code after sync
				if ((pop_item.lvl <= mvfb_pkg::LVL_PICTURE && pop_item.lvl < lvl_cur) ||
				    (lvl_cur == mvfb_pkg::LVL_SYNC && pop_item.lvl >= mvfb_pkg::LVL_PICTURE)) begin
					bnd = mvfb_pkg::BND_PREFIX;
				end
				lvl_next = pop_item.lvl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= mvfb_pkg::LVL_SYNC;
			out_valid_q  <= 1'b0;
			boundary_q   <= mvfb_pkg::BND_NONE;
			code_valid_q <= 1'b0;
			code_byte_q  <= '0;
		end else begin
			if (pop) begin
				level_q      <= lvl_next;
				out_valid_q  <= 1'b1;
				boundary_q   <= bnd;
				code_valid_q <= pop_item.code_valid;
				code_byte_q  <= pop_item.code;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.boundary   = boundary_q;
	assign out_ch.code_valid = code_valid_q;
	assign out_ch.code_byte  = code_byte_q;

	`ASSERT_IMPL(a_plain_bnd, !code_valid_q, boundary_q == mvfb_pkg::BND_NONE, "boundary on data byte")
	`ASSERT_IMPL(a_plain_code, !code_valid_q, code_byte_q == '0, "code on a data byte")

endmodule

/* rtl/core/mpeg_video_frame_boundary_finder.sv */
// MPEG-1/2 video frame boundary finder, top level
// depends on mvfb_pkg, mvfb_in_if, mvfb_out_if, mvfb_front, mvfb_fifo, mvfb_back
//
// in_ch takes one byte of a video elementary stream per item, with resync
// to drop the level state back to sync before that byte is looked at.
// out_ch gives exactly one result item per input byte, in order:
// boundary (0 none, 1 frame starts at the prefix three bytes back,
// 2 frame starts after this byte), code_valid and code_byte for the
// code byte that follows a 00 00 01 prefix.
// The front scans prefixes and classifies, a four-entry queue follows,
// the back tracks the level and holds the result register.
// Each byte is written into the queue and its result then into the result
// register; throughput is one byte per cycle while out_ch does not stall, set
// by the single level-state update in the back.
// When out_ch stalls the result register holds, the queue fills, and
// in_ch.ready drops once the four queue entries are taken.
// After reset the level is sync, no prefix is in progress, the queue is
// empty and the result register holds nothing.
module mpeg_video_frame_boundary_finder (
	input  logic         clk,
	input  logic         arst_n,
	mvfb_in_if.sink      in_ch,
	mvfb_out_if.source   out_ch
);

	logic              push_valid;
	logic              push_ready;
	mvfb_pkg::q_item_t push_item;
	logic              pop_valid;
	logic              pop_ready;
	mvfb_pkg::q_item_t pop_item;

	mvfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	mvfb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mvfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_ch    (out_ch)
	);

endmodule
